// File: rtl/sbag_pkg.sv
// sbag_pkg: shared types and constants of the scaled blit address generator
// depends on nothing; every other file of the block but sbag_stream_if refers to it by scoped names

package sbag_pkg;

	// field and register widths
	localparam int DIM_W     = 13;
	localparam int COORD_W   = 12;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;

	// largest dimension used by the layout; larger register values are clamped
	localparam int MAX_DIM = 4096;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE     = 3'd4;

	// register reset values
	localparam logic [DIM_W-1:0]  RST_SOURCE_WIDTH   = 13'd320;
	localparam logic [DIM_W-1:0]  RST_SOURCE_HEIGHT  = 13'd240;
	localparam logic [DIM_W-1:0]  RST_DISPLAY_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]  RST_DISPLAY_HEIGHT = 13'd480;
	localparam logic [MODE_W-1:0] RST_SCALE_MODE     = 2'd1;

	// scale modes; any other code fits to the display
	localparam logic [MODE_W-1:0] MODE_STRETCH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ASPECT  = 2'd1;

	// shared arithmetic unit
	typedef enum logic [0:0] {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

	// layout sequencer
	typedef enum logic [3:0] {
		LY_IDLE,
		LY_FW,
		LY_FH,
		LY_MULW,
		LY_MULH,
		LY_PROD,
		LY_PH,
		LY_PROD2,
		LY_IW,
		LY_CSTEP,
		LY_RSTEP,
		LY_DONE
	} ly_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ly_sts_t;

	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [COORD_W-1:0] off_col;
		logic [COORD_W-1:0] off_row;
	} layout_t;

	// raster walker control
	typedef struct packed {
		logic load;
		logic step;
	} rs_ctl_t;

	// top level item handling
	typedef enum logic [1:0] {
		TP_IDLE,
		TP_LAYOUT,
		TP_PIXEL
	} tp_state_t;

	// channel payloads
	typedef struct packed {
		logic restart;
	} adv_t;

	typedef struct packed {
		logic [COORD_W-1:0] src_col;
		logic [COORD_W-1:0] src_row;
		logic [COORD_W-1:0] dst_col;
		logic [COORD_W-1:0] dst_row;
		logic               frame_last;
		logic               bad_size;
	} pix_t;

endpackage

// File: rtl/sbag_stream_if.sv
// sbag_stream_if: valid/ready channel carrying one payload item
// payload type is given at instantiation, normally a struct from sbag_pkg

interface sbag_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sbag_alu.sv
// sbag_alu: bit-serial multiply and restoring divide sharing one adder
// depends on sbag_pkg for the operation code and control/status structs

module sbag_alu #(
	parameter int DIV_W = 29
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbag_pkg::alu_ctl_t        ctl,
	input  logic [DIV_W-1:0]          num,
	input  logic [sbag_pkg::DIM_W-1:0] den,
	output sbag_pkg::alu_sts_t        sts,
	output logic [DIV_W-1:0]          quo
);

	localparam int DW    = sbag_pkg::DIM_W;
	localparam int HI_W  = DW + 1;
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [HI_W-1:0]  hi_q;
	logic [DIV_W-1:0] lo_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	sbag_pkg::alu_op_t op_q;

	logic [HI_W-1:0] trial;
	logic [HI_W-1:0] add_a;
	logic [HI_W-1:0] add_b;
	logic            add_cin;
	logic [HI_W:0]   sum;
	logic            last;

	// shared adder: trial subtract for divide, conditional add for multiply
	always_comb begin
		trial = {hi_q[DW-1:0], lo_q[DIV_W-1]};
		if (op_q == sbag_pkg::ALU_DIV) begin
			add_a   = trial;
			add_b   = ~{1'b0, den_q};
			add_cin = 1'b1;
		end else begin
			add_a   = hi_q;
			add_b   = lo_q[0] ? {1'b0, den_q} : '0;
			add_cin = 1'b0;
		end
		sum  = {1'b0, add_a} + {1'b0, add_b} + {{HI_W{1'b0}}, add_cin};
		last = (cnt_q == CNT_W'(1));
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= sbag_pkg::ALU_DIV;
		end else begin
			done_q <= busy_q && last;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= (ctl.op == sbag_pkg::ALU_DIV) ? CNT_W'(DIV_W) : CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// working registers: remainder/high product and quotient/low product
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			hi_q  <= '0;
			lo_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (op_q == sbag_pkg::ALU_DIV) begin
				hi_q <= sum[HI_W] ? sum[HI_W-1:0] : trial;
				lo_q <= {lo_q[DIV_W-2:0], sum[HI_W]};
			end else begin
				hi_q <= {1'b0, sum[HI_W-1:1]};
				lo_q <= {lo_q[DIV_W-1:DW], sum[0], lo_q[DW-1:1]};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo = (op_q == sbag_pkg::ALU_MUL) ? DIV_W'({hi_q[DW-1:0], lo_q[DW-1:0]}) : lo_q;

	// a new operation never starts on top of a running one
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("alu started while busy");

endmodule

// File: rtl/sbag_layout.sv
// sbag_layout: sequencer that works out layout size, centring and steps
// depends on sbag_pkg and sbag_alu (one shared multiply/divide unit)

module sbag_layout #(
	parameter int FRAC_BITS = 16,
	parameter int STEP_W    = 29,
	parameter int DIV_W     = 29
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sbag_pkg::DIM_W-1:0]  source_width,
	input  logic [sbag_pkg::DIM_W-1:0]  source_height,
	input  logic [sbag_pkg::DIM_W-1:0]  display_width,
	input  logic [sbag_pkg::DIM_W-1:0]  display_height,
	input  logic [sbag_pkg::MODE_W-1:0] scale_mode,
	output sbag_pkg::ly_sts_t           sts,
	output sbag_pkg::layout_t           layout,
	output logic [STEP_W-1:0]           col_step,
	output logic [STEP_W-1:0]           row_step
);

	localparam int DW = sbag_pkg::DIM_W;
	localparam int CW = sbag_pkg::COORD_W;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
		if (v == '0) begin
			return DW'(1);
		end
		if (32'(v) > sbag_pkg::MAX_DIM) begin
			return DW'(sbag_pkg::MAX_DIM);
		end
		return v;
	endfunction

	sbag_pkg::ly_state_t state_q, state_d;
	logic                issue_q;
	logic [DW-1:0]       fac_q;
	logic [DW-1:0]       iw_q;
	logic [DW-1:0]       ih_q;
	logic [DIV_W-1:0]    tmp_q;
	logic [STEP_W-1:0]   csteps_q;
	logic [STEP_W-1:0]   rsteps_q;

	logic [DW-1:0]       sw, sh, dw, dh;
	sbag_pkg::alu_ctl_t  alu_ctl;
	sbag_pkg::alu_sts_t  alu_sts;
	logic [DIV_W-1:0]    alu_num;
	logic [DW-1:0]       alu_den;
	logic [DIV_W-1:0]    quo;
	logic [DW-1:0]       quo_d;
	logic [DW-1:0]       fac_min;
	logic                ph_big;
	logic                size_zero;

	// clamped dimensions and decision terms
	always_comb begin
		sw        = clamp_dim(source_width);
		sh        = clamp_dim(source_height);
		dw        = clamp_dim(display_width);
		dh        = clamp_dim(display_height);
		quo_d     = quo[DW-1:0];
		fac_min   = (quo_d < fac_q) ? quo_d : fac_q;
		ph_big    = (quo > DIV_W'(dh));
		size_zero = (iw_q == '0) || (ih_q == '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbag_pkg::LY_IDLE: begin
				if (start) begin
					state_d = (scale_mode == sbag_pkg::MODE_STRETCH) ?
						sbag_pkg::LY_CSTEP : sbag_pkg::LY_FW;
				end
			end
			sbag_pkg::LY_FW: begin
				if (alu_sts.done) begin
					state_d = (scale_mode == sbag_pkg::MODE_ASPECT) ?
						sbag_pkg::LY_FH : sbag_pkg::LY_PROD;
				end
			end
			sbag_pkg::LY_FH: begin
				if (alu_sts.done) begin
					state_d = (fac_min != '0) ? sbag_pkg::LY_MULW : sbag_pkg::LY_PROD;
				end
			end
			sbag_pkg::LY_MULW: begin
				if (alu_sts.done) state_d = sbag_pkg::LY_MULH;
			end
			sbag_pkg::LY_MULH: begin
				if (alu_sts.done) state_d = sbag_pkg::LY_CSTEP;
			end
			sbag_pkg::LY_PROD: begin
				if (alu_sts.done) state_d = sbag_pkg::LY_PH;
			end
			sbag_pkg::LY_PH: begin
				if (alu_sts.done) begin
					state_d = ph_big ? sbag_pkg::LY_PROD2 : sbag_pkg::LY_CSTEP;
				end
			end
			sbag_pkg::LY_PROD2: begin
				if (alu_sts.done) state_d = sbag_pkg::LY_IW;
			end
			sbag_pkg::LY_IW: begin
				if (alu_sts.done) state_d = sbag_pkg::LY_CSTEP;
			end
			sbag_pkg::LY_CSTEP: begin
				if (size_zero) begin
					state_d = sbag_pkg::LY_DONE;
				end else if (alu_sts.done) begin
					state_d = sbag_pkg::LY_RSTEP;
				end
			end
			sbag_pkg::LY_RSTEP: begin
				if (alu_sts.done) state_d = sbag_pkg::LY_DONE;
			end
			sbag_pkg::LY_DONE: begin
				state_d = sbag_pkg::LY_IDLE;
			end
			default: begin
				state_d = sbag_pkg::LY_IDLE;
			end
		endcase
	end

	// operation issued in each state
	always_comb begin
		alu_ctl.start = 1'b0;
		alu_ctl.op    = sbag_pkg::ALU_DIV;
		alu_num       = '0;
		alu_den       = '0;
		case (state_q)
			sbag_pkg::LY_FW: begin
				alu_ctl.start = issue_q;
				alu_num       = DIV_W'(dw);
				alu_den       = sw;
			end
			sbag_pkg::LY_FH: begin
				alu_ctl.start = issue_q;
				alu_num       = DIV_W'(dh);
				alu_den       = sh;
			end
			sbag_pkg::LY_MULW: begin
				alu_ctl.start = issue_q;
				alu_ctl.op    = sbag_pkg::ALU_MUL;
				alu_num       = DIV_W'(fac_q);
				alu_den       = sw;
			end
			sbag_pkg::LY_MULH: begin
				alu_ctl.start = issue_q;
				alu_ctl.op    = sbag_pkg::ALU_MUL;
				alu_num       = DIV_W'(fac_q);
				alu_den       = sh;
			end
			sbag_pkg::LY_PROD: begin
				alu_ctl.start = issue_q;
				alu_ctl.op    = sbag_pkg::ALU_MUL;
				alu_num       = DIV_W'(sh);
				alu_den       = dw;
			end
			sbag_pkg::LY_PH: begin
				alu_ctl.start = issue_q;
				alu_num       = tmp_q;
				alu_den       = sw;
			end
			sbag_pkg::LY_PROD2: begin
				alu_ctl.start = issue_q;
				alu_ctl.op    = sbag_pkg::ALU_MUL;
				alu_num       = DIV_W'(sw);
				alu_den       = dh;
			end
			sbag_pkg::LY_IW: begin
				alu_ctl.start = issue_q;
				alu_num       = tmp_q;
				alu_den       = sh;
			end
			sbag_pkg::LY_CSTEP: begin
				alu_ctl.start = issue_q && !size_zero;
				alu_num       = DIV_W'({sw, {FRAC_BITS{1'b0}}});
				alu_den       = iw_q;
			end
			sbag_pkg::LY_RSTEP: begin
				alu_ctl.start = issue_q;
				alu_num       = DIV_W'({sh, {FRAC_BITS{1'b0}}});
				alu_den       = ih_q;
			end
			default: begin
				alu_ctl.start = 1'b0;
			end
		endcase
	end

	sbag_alu #(
		.DIV_W (DIV_W)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.num    (alu_num),
		.den    (alu_den),
		.sts    (alu_sts),
		.quo    (quo)
	);

	// sequencer state; an operation issues in the first cycle of its state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbag_pkg::LY_IDLE;
			issue_q <= 1'b0;
		end else begin
			state_q <= state_d;
			issue_q <= (state_d != state_q);
		end
	end

	// capture results as each operation completes
	always_ff @(posedge clk) begin
		case (state_q)
			sbag_pkg::LY_IDLE: begin
				if (start && scale_mode == sbag_pkg::MODE_STRETCH) begin
					iw_q <= dw;
					ih_q <= dh;
				end
			end
			sbag_pkg::LY_FW: begin
				if (alu_sts.done) fac_q <= quo_d;
			end
			sbag_pkg::LY_FH: begin
				if (alu_sts.done) fac_q <= fac_min;
			end
			sbag_pkg::LY_MULW: begin
				if (alu_sts.done) iw_q <= quo_d;
			end
			sbag_pkg::LY_MULH: begin
				if (alu_sts.done) ih_q <= quo_d;
			end
			sbag_pkg::LY_PROD: begin
				if (alu_sts.done) tmp_q <= quo;
			end
			sbag_pkg::LY_PH: begin
				if (alu_sts.done) begin
					if (ph_big) begin
						ih_q <= dh;
					end else begin
						ih_q <= quo_d;
						iw_q <= dw;
					end
				end
			end
			sbag_pkg::LY_PROD2: begin
				if (alu_sts.done) tmp_q <= quo;
			end
			sbag_pkg::LY_IW: begin
				if (alu_sts.done) iw_q <= quo_d;
			end
			sbag_pkg::LY_CSTEP: begin
				if (size_zero) begin
					csteps_q <= '0;
					rsteps_q <= '0;
				end else if (alu_sts.done) begin
					csteps_q <= quo[STEP_W-1:0];
				end
			end
			sbag_pkg::LY_RSTEP: begin
				if (alu_sts.done) rsteps_q <= quo[STEP_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// results; offsets center the layout on the display
	always_comb begin
		layout.width   = iw_q;
		layout.height  = ih_q;
		layout.off_col = CW'((dw - iw_q) >> 1);
		layout.off_row = CW'((dh - ih_q) >> 1);
		col_step       = csteps_q;
		row_step       = rsteps_q;
		sts.busy       = (state_q != sbag_pkg::LY_IDLE);
		sts.done       = (state_q == sbag_pkg::LY_DONE);
	end

endmodule

// File: rtl/sbag_raster.sv
// sbag_raster: raster walker holding the layout and the per-pixel accumulators
// depends on sbag_pkg for the layout, control and pixel structs

module sbag_raster #(
	parameter int FRAC_BITS = 16,
	parameter int STEP_W    = 29
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sbag_pkg::rs_ctl_t ctl,
	input  sbag_pkg::layout_t layout,
	input  logic [STEP_W-1:0] col_step,
	input  logic [STEP_W-1:0] row_step,
	output sbag_pkg::pix_t    pix
);

	localparam int DW = sbag_pkg::DIM_W;
	localparam int CW = sbag_pkg::COORD_W;

	logic [DW-1:0]        lw_q, lh_q;
	logic [CW-1:0]        ocol_q, orow_q;
	logic [STEP_W-1:0]    cstep_q, rstep_q;
	logic [DW-1:0]        out_col_q, out_row_q;
	logic [STEP_W-1:0]    col_acc_q;
	logic [FRAC_BITS-1:0] row_frac_q;
	logic [CW-1:0]        src_row_q;

	logic                 bad;
	logic                 col_end, row_end;
	logic [STEP_W:0]      rf_sum;
	logic [CW-1:0]        src_row_nx;

	// current pixel and next-row terms
	always_comb begin
		bad        = (lw_q == '0) || (lh_q == '0);
		col_end    = ({1'b0, out_col_q} + (DW+1)'(1)) == {1'b0, lw_q};
		row_end    = ({1'b0, out_row_q} + (DW+1)'(1)) == {1'b0, lh_q};
		rf_sum     = {{(STEP_W+1-FRAC_BITS){1'b0}}, row_frac_q} + {1'b0, rstep_q};
		src_row_nx = src_row_q + rf_sum[FRAC_BITS +: CW];
		if (bad) begin
			pix            = '0;
			pix.frame_last = 1'b1;
			pix.bad_size   = 1'b1;
		end else begin
			pix.src_col    = col_acc_q[FRAC_BITS +: CW];
			pix.src_row    = src_row_q;
			pix.dst_col    = ocol_q + out_col_q[CW-1:0];
			pix.dst_row    = orow_q + out_row_q[CW-1:0];
			pix.frame_last = col_end && row_end;
			pix.bad_size   = 1'b0;
		end
	end

	// layout copy, taken when a new layout is ready
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lw_q    <= layout.width;
			lh_q    <= layout.height;
			ocol_q  <= layout.off_col;
			orow_q  <= layout.off_row;
			cstep_q <= col_step;
			rstep_q <= row_step;
		end
	end

	// raster position and source accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_col_q  <= '0;
			out_row_q  <= '0;
			col_acc_q  <= '0;
			row_frac_q <= '0;
			src_row_q  <= '0;
		end else if (ctl.load) begin
			out_col_q  <= '0;
			out_row_q  <= '0;
			col_acc_q  <= '0;
			row_frac_q <= '0;
			src_row_q  <= '0;
		end else if (ctl.step && !bad) begin
			if (col_end) begin
				out_col_q <= '0;
				col_acc_q <= '0;
				if (row_end) begin
					out_row_q  <= '0;
					src_row_q  <= '0;
					row_frac_q <= '0;
				end else begin
					out_row_q  <= out_row_q + DW'(1);
					src_row_q  <= src_row_nx;
					row_frac_q <= rf_sum[FRAC_BITS-1:0];
				end
			end else begin
				out_col_q <= out_col_q + DW'(1);
				col_acc_q <= col_acc_q + cstep_q;
			end
		end
	end

endmodule

// File: rtl/scaled_blit_address_generator_top.sv
// Nearest-neighbor scaler address generator. Each advance item yields one output pixel in raster
// order with its source and destination coordinates, an end-of-frame flag and a zero-size flag.
// An item that does not restart goes to the pixel state and then into the output register once
// that register is free of the sink; the input reopens as that register loads. A restart (and the
// first item after reset) first recomputes the layout on one bit-serial multiply/divide unit with
// a DIV_W = max(26, 13 + FRAC_BITS) bit dividend. Aspect mode falling back to the fit rule needs up
// to six divisions and two multiplies; fit mode needs one division fewer and stretch mode needs two
// divisions. The block takes no new item until the current one has reached the output register.
// Configuration writes take effect at the next layout computation.

module scaled_blit_address_generator_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sbag_stream_if.sink                    adv,
	sbag_stream_if.source                  pix,
	input  logic                           cfg_we,
	input  logic [sbag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbag_pkg::CFG_W-1:0]     cfg_data
);

	localparam int DW     = sbag_pkg::DIM_W;
	localparam int STEP_W = DW + FRAC_BITS;
	localparam int DIV_W  = (STEP_W > 2 * DW) ? STEP_W : 2 * DW;

	logic [DW-1:0]               source_width_q;
	logic [DW-1:0]               source_height_q;
	logic [DW-1:0]               display_width_q;
	logic [DW-1:0]               display_height_q;
	logic [sbag_pkg::MODE_W-1:0] scale_mode_q;

	sbag_pkg::tp_state_t tp_q, tp_d;
	logic                lay_valid_q;
	logic                out_valid_q;
	sbag_pkg::pix_t      out_data_q;

	logic                accept;
	logic                need_layout;
	logic                out_free;
	logic                ly_start;
	sbag_pkg::ly_sts_t   ly_sts;
	sbag_pkg::layout_t   layout;
	logic [STEP_W-1:0]   col_step, row_step;
	sbag_pkg::rs_ctl_t   rs_ctl;
	sbag_pkg::pix_t      rs_pix;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q   <= sbag_pkg::RST_SOURCE_WIDTH;
			source_height_q  <= sbag_pkg::RST_SOURCE_HEIGHT;
			display_width_q  <= sbag_pkg::RST_DISPLAY_WIDTH;
			display_height_q <= sbag_pkg::RST_DISPLAY_HEIGHT;
			scale_mode_q     <= sbag_pkg::RST_SCALE_MODE;
		end else if (cfg_we) begin
			case (cfg_index)
				sbag_pkg::REG_SOURCE_WIDTH:   source_width_q   <= cfg_data[DW-1:0];
				sbag_pkg::REG_SOURCE_HEIGHT:  source_height_q  <= cfg_data[DW-1:0];
				sbag_pkg::REG_DISPLAY_WIDTH:  display_width_q  <= cfg_data[DW-1:0];
				sbag_pkg::REG_DISPLAY_HEIGHT: display_height_q <= cfg_data[DW-1:0];
				sbag_pkg::REG_SCALE_MODE:     scale_mode_q     <= cfg_data[sbag_pkg::MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// item handling: next state
	always_comb begin
		tp_d = tp_q;
		case (tp_q)
			sbag_pkg::TP_IDLE: begin
				if (accept) begin
					tp_d = need_layout ? sbag_pkg::TP_LAYOUT : sbag_pkg::TP_PIXEL;
				end
			end
			sbag_pkg::TP_LAYOUT: begin
				if (ly_sts.done) tp_d = sbag_pkg::TP_PIXEL;
			end
			sbag_pkg::TP_PIXEL: begin
				if (out_free) tp_d = sbag_pkg::TP_IDLE;
			end
			default: begin
				tp_d = sbag_pkg::TP_IDLE;
			end
		endcase
	end

	// item handling: controls
	always_comb begin
		adv.ready   = (tp_q == sbag_pkg::TP_IDLE);
		accept      = adv.valid && adv.ready;
		need_layout = adv.data.restart || !lay_valid_q;
		out_free    = !out_valid_q || pix.ready;
		ly_start    = accept && need_layout;
		rs_ctl.load = ly_sts.done;
		rs_ctl.step = (tp_q == sbag_pkg::TP_PIXEL) && out_free;
	end

	sbag_layout #(
		.FRAC_BITS (FRAC_BITS),
		.STEP_W    (STEP_W),
		.DIV_W     (DIV_W)
	) u_layout (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (ly_start),
		.source_width   (source_width_q),
		.source_height  (source_height_q),
		.display_width  (display_width_q),
		.display_height (display_height_q),
		.scale_mode     (scale_mode_q),
		.sts            (ly_sts),
		.layout         (layout),
		.col_step       (col_step),
		.row_step       (row_step)
	);

	sbag_raster #(
		.FRAC_BITS (FRAC_BITS),
		.STEP_W    (STEP_W)
	) u_raster (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rs_ctl),
		.layout   (layout),
		.col_step (col_step),
		.row_step (row_step),
		.pix      (rs_pix)
	);

	// state, layout valid flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q        <= sbag_pkg::TP_IDLE;
			lay_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			tp_q <= tp_d;
			if (ly_sts.done) begin
				lay_valid_q <= 1'b1;
			end
			if (rs_ctl.step) begin
				out_valid_q <= 1'b1;
			end else if (pix.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rs_ctl.step) begin
			out_data_q <= rs_pix;
		end
	end

	assign pix.valid = out_valid_q;
	assign pix.data  = out_data_q;

	// one item at a time: an accepted item closes the input for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		adv.valid && adv.ready |=> !adv.ready)
		else $error("input accepted on consecutive cycles");

	// a zero-size layout gives zero coordinates and ends the frame
	a_bad_size_item: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.data.bad_size |->
			pix.data.frame_last && pix.data.src_col == '0 && pix.data.dst_col == '0)
		else $error("bad size item with nonzero coordinates");

	// the layout completes only for an item that asked for it
	a_layout_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		ly_sts.done |-> tp_q == sbag_pkg::TP_LAYOUT)
		else $error("layout completed outside of a restart");

endmodule
